// ===== design/gjd_pkg.sv =====
// ----------------------------------------------------------------------------
// gjd_pkg
// Shared types, codes and constants for the Gregorian / Julian day converter.
// ----------------------------------------------------------------------------
package gjd_pkg;

    localparam logic [1:0] MODE_DATE   = 2'd0;
    localparam logic [1:0] MODE_DAYNUM = 2'd1;
    localparam logic [1:0] MODE_UNIX   = 2'd2;

    localparam logic [21:0] JDN_UNIX_EPOCH = 22'd2440588;
    localparam logic [21:0] JDN_OFFSET     = 22'd32045;
    localparam logic [13:0] YEAR_SHIFT     = 14'd4800;
    localparam logic [11:0] YEAR_MIN       = 12'd1858;
    localparam logic [11:0] YEAR_MAX       = 12'd2558;

    // reciprocals: floor(x / d) = (x * R) >> k over the input range
    localparam logic [28:0] DAY675_RECIP = 29'd407226529;  // /675,    k = 38
    localparam logic [14:0] C100_RECIP   = 15'd20972;      // /100,    k = 21
    localparam logic [25:0] P146_RECIP   = 26'd60207212;   // /146097, k = 43
    localparam logic [22:0] SEVEN_RECIP  = 23'd4793491;    // /7,      k = 25
    localparam logic [25:0] Y1461_RECIP  = 26'd47035919;   // /1461,   k = 36
    localparam logic [11:0] M153_RECIP   = 12'd3427;       // /153,    k = 19
    localparam logic [8:0]  FIVE_RECIP   = 9'd410;         // /5,      k = 11

    localparam logic [24:0] RICH_ADD     = 25'd274277;
    localparam logic [22:0] RICH_BASE    = 23'd1363;
    localparam logic [10:0] CYCLE_4Y     = 11'd1461;
    localparam logic [7:0]  CYCLE_5M     = 8'd153;
    localparam logic [13:0] YEAR_BIAS    = 14'd4716;
    localparam logic [13:0] YB_MIN       = 14'd6574;       // 1858 + 4716
    localparam logic [13:0] YB_MAX       = 14'd7274;       // 2558 + 4716

    typedef struct packed {
        logic [21:0] jdn;
        logic        is_date;
        logic        bad;
    } jdn_item_t;

    // (153 * mm + 2) / 5 for the March-based month index
    function automatic logic [8:0] days_before(input logic [3:0] mm);
        logic [8:0] res;
        begin
            case (mm)
                4'd0:    res = 9'd0;
                4'd1:    res = 9'd31;
                4'd2:    res = 9'd61;
                4'd3:    res = 9'd92;
                4'd4:    res = 9'd122;
                4'd5:    res = 9'd153;
                4'd6:    res = 9'd184;
                4'd7:    res = 9'd214;
                4'd8:    res = 9'd245;
                4'd9:    res = 9'd275;
                4'd10:   res = 9'd306;
                4'd11:   res = 9'd337;
                4'd12:   res = 9'd367;
                default: res = 9'd0;
            endcase
            return res;
        end
    endfunction

endpackage

// ===== design/gjd_front.sv =====
// ----------------------------------------------------------------------------
// gjd_front
// Two stages forming the day number from a date, a day number or Unix seconds.
// ----------------------------------------------------------------------------
module gjd_front
    import gjd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [11:0] year_in,
    input  logic [3:0]  month_in,
    input  logic [4:0]  day_in,
    input  logic [21:0] day_number_in,
    input  logic [34:0] unix_seconds,
    output logic        out_valid,
    input  logic        out_ready,
    output jdn_item_t   out_item
);

    logic        a_valid_reg;
    logic [1:0]  a_mode_reg;
    logic [21:0] a_jin_reg;
    logic [18:0] a_secq_reg;
    logic [13:0] a_yy_reg;
    logic [21:0] a_p365_reg;
    logic [7:0]  a_q100_reg;
    logic [8:0]  a_dbm_reg;
    logic [4:0]  a_day_reg;
    logic        a_bad_reg;
    logic        b_valid_reg;
    jdn_item_t   b_item_reg;

    logic        a_en;
    logic        b_en;
    logic        early;
    logic [3:0]  mm;
    logic [13:0] yy_next;
    logic [56:0] sec_prod;
    logic [28:0] c100_prod;
    logic [21:0] p365_next;
    logic        leap;
    logic        bad_next;
    logic [21:0] date_jdn;
    jdn_item_t   b_item_next;

    assign b_en     = !b_valid_reg || out_ready;
    assign a_en     = !a_valid_reg || b_en;
    assign in_ready = a_en;

    // stage A
    assign early     = (month_in <= 4'd2);
    assign mm        = early ? (month_in + 4'd9) : (month_in - 4'd3);
    assign yy_next   = 14'(year_in) + YEAR_SHIFT - 14'(early);
    assign sec_prod  = {29'd0, unix_seconds[34:7]} * {28'd0, DAY675_RECIP};
    assign c100_prod = {15'd0, yy_next} * {14'd0, C100_RECIP};
    assign p365_next = 22'(yy_next) * 22'd365;

    assign leap = (year_in[1:0] == 2'd0) &&
                  !(year_in == 12'd1900 || year_in == 12'd2100 || year_in == 12'd2200 ||
                    year_in == 12'd2300 || year_in == 12'd2500);

    assign bad_next = (year_in < YEAR_MIN) || (year_in > YEAR_MAX) ||
                      (month_in == 4'd0) || (month_in > 4'd12) || (day_in == 5'd0) ||
                      (month_in == 4'd2 && day_in == 5'd29 && !leap);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_en)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_en)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_en && in_valid)
        begin
            a_mode_reg <= mode;
            a_jin_reg  <= day_number_in;
            a_secq_reg <= sec_prod[56:38];
            a_yy_reg   <= yy_next;
            a_p365_reg <= p365_next;
            a_q100_reg <= c100_prod[28:21];
            a_dbm_reg  <= days_before(mm);
            a_day_reg  <= day_in;
            a_bad_reg  <= bad_next;
        end
        if (b_en && a_valid_reg)
        begin
            b_item_reg <= b_item_next;
        end
    end

    // stage B
    assign date_jdn = 22'(a_day_reg) + 22'(a_dbm_reg) + a_p365_reg + 22'(a_yy_reg[13:2])
                    - 22'(a_q100_reg) + 22'(a_q100_reg[7:2]) - JDN_OFFSET;

    always_comb
    begin
        b_item_next.is_date = (a_mode_reg == MODE_DATE);
        b_item_next.bad     = a_bad_reg;
        case (a_mode_reg)
            MODE_DATE: b_item_next.jdn = date_jdn;
            MODE_UNIX: b_item_next.jdn = JDN_UNIX_EPOCH + 22'(a_secq_reg);
            default:   b_item_next.jdn = a_jin_reg;
        endcase
    end

    assign out_valid = b_valid_reg;
    assign out_item  = b_item_reg;

endmodule

// ===== design/gjd_richards.sv =====
// ----------------------------------------------------------------------------
// gjd_richards
// Seven-stage day number to Gregorian date, weekday and validity.
// ----------------------------------------------------------------------------
module gjd_richards
    import gjd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  jdn_item_t   in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [21:0] day_number_out,
    output logic [11:0] year_out,
    output logic [3:0]  month_out,
    output logic [4:0]  day_out,
    output logic [2:0]  weekday,
    output logic        invalid
);

    localparam int NSTAGE = 7;

    typedef struct packed {
        logic [21:0] jdn;
        logic [2:0]  wd;
        logic        is_date;
        logic        bad;
    } carry_t;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] en;

    carry_t      c_cr_reg, d_cr_reg, e_cr_reg, f_cr_reg, g_cr_reg;
    logic [7:0]  c_cq_reg;
    logic [19:0] c_q7_reg;
    logic [24:0] d_e_reg;
    logic [13:0] e_q1_reg;
    logic [24:0] e_e_reg;
    logic [13:0] f_q1_reg;
    logic [10:0] f_h_reg;
    logic [13:0] g_q1_reg;
    logic [10:0] g_h_reg;
    logic [3:0]  g_qh_reg;
    logic [21:0] h_jdn_reg;
    logic [2:0]  h_wd_reg;
    logic [7:0]  h_rem_reg;
    logic [3:0]  h_month_reg;
    logic [11:0] h_year_reg;
    logic        h_bad_reg;
    logic [21:0] i_jdn_reg;
    logic [11:0] i_year_reg;
    logic [3:0]  i_month_reg;
    logic [4:0]  i_day_reg;
    logic [2:0]  i_wd_reg;
    logic        i_bad_reg;

    logic [24:0] c_x;
    logic [50:0] c_prod;
    logic [44:0] c_q7prod;
    carry_t      c_cr_next;
    logic [8:0]  d_t3;
    logic [22:0] d_f;
    logic [22:0] d_m7;
    logic [22:0] d_r7;
    carry_t      d_cr_next;
    logic [50:0] e_prod;
    logic [24:0] f_m;
    logic [24:0] f_r;
    logic [8:0]  f_g;
    logic [10:0] f_h_next;
    logic [22:0] g_prod;
    logic [11:0] h_m153;
    logic [11:0] h_rem;
    logic [3:0]  h_mp;
    logic [3:0]  h_month_next;
    logic [13:0] h_ys;
    logic [13:0] h_yd;
    logic        h_bad_next;
    logic [16:0] i_dprod;

    always_comb
    begin
        en[NSTAGE-1] = !valid_reg[NSTAGE-1] || out_ready;
        for (int i = NSTAGE - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < NSTAGE; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // stage C: century correction quotient and weekday quotient
    assign c_x      = {1'b0, in_item.jdn, 2'b00} + RICH_ADD;
    assign c_prod   = {26'd0, c_x} * {25'd0, P146_RECIP};
    assign c_q7prod = {23'd0, in_item.jdn} * {22'd0, SEVEN_RECIP};

    always_comb
    begin
        c_cr_next.jdn     = in_item.jdn;
        c_cr_next.wd      = 3'd0;
        c_cr_next.is_date = in_item.is_date;
        c_cr_next.bad     = in_item.bad;
    end

    // stage D
    assign d_t3 = {c_cq_reg, 1'b0} + {1'b0, c_cq_reg};
    assign d_f  = 23'(c_cr_reg.jdn) + RICH_BASE + 23'(d_t3[8:2]);
    assign d_m7 = {c_q7_reg, 3'b000} - 23'(c_q7_reg);
    assign d_r7 = 23'(c_cr_reg.jdn) - d_m7;

    always_comb
    begin
        d_cr_next    = c_cr_reg;
        d_cr_next.wd = d_r7[2:0] + 3'd1;
    end

    // stage E
    assign e_prod = {26'd0, d_e_reg} * {25'd0, Y1461_RECIP};

    // stage F
    assign f_m      = {11'd0, e_q1_reg} * {14'd0, CYCLE_4Y};
    assign f_r      = e_e_reg - f_m;
    assign f_g      = f_r[10:2];
    assign f_h_next = {f_g, 2'b00} + {2'b00, f_g} + 11'd2;

    // stage G
    assign g_prod = {12'd0, f_h_reg} * {11'd0, M153_RECIP};

    // stage H
    assign h_m153       = {8'd0, g_qh_reg} * {4'd0, CYCLE_5M};
    assign h_rem        = {1'b0, g_h_reg} - h_m153;
    assign h_mp         = g_qh_reg + 4'd2;
    assign h_month_next = ((h_mp >= 4'd12) ? (h_mp - 4'd12) : h_mp) + 4'd1;
    assign h_ys         = g_q1_reg + 14'(h_month_next <= 4'd2);
    assign h_yd         = h_ys - YEAR_BIAS;
    assign h_bad_next   = g_cr_reg.is_date ? g_cr_reg.bad
                                           : ((h_ys < YB_MIN) || (h_ys > YB_MAX));

    // stage I
    assign i_dprod = {9'd0, h_rem_reg} * {8'd0, FIVE_RECIP};

    always_ff @(posedge clk)
    begin
        if (en[0] && in_valid)
        begin
            c_cr_reg <= c_cr_next;
            c_cq_reg <= c_prod[50:43];
            c_q7_reg <= c_q7prod[44:25];
        end
        if (en[1] && valid_reg[0])
        begin
            d_cr_reg <= d_cr_next;
            d_e_reg  <= {d_f, 2'b11};
        end
        if (en[2] && valid_reg[1])
        begin
            e_cr_reg <= d_cr_reg;
            e_q1_reg <= e_prod[49:36];
            e_e_reg  <= d_e_reg;
        end
        if (en[3] && valid_reg[2])
        begin
            f_cr_reg <= e_cr_reg;
            f_q1_reg <= e_q1_reg;
            f_h_reg  <= f_h_next;
        end
        if (en[4] && valid_reg[3])
        begin
            g_cr_reg <= f_cr_reg;
            g_q1_reg <= f_q1_reg;
            g_h_reg  <= f_h_reg;
            g_qh_reg <= g_prod[22:19];
        end
        if (en[5] && valid_reg[4])
        begin
            h_jdn_reg   <= g_cr_reg.jdn;
            h_wd_reg    <= g_cr_reg.wd;
            h_rem_reg   <= h_rem[7:0];
            h_month_reg <= h_month_next;
            h_year_reg  <= h_yd[11:0];
            h_bad_reg   <= h_bad_next;
        end
        if (en[6] && valid_reg[5])
        begin
            i_jdn_reg   <= h_jdn_reg;
            i_year_reg  <= h_year_reg;
            i_month_reg <= h_month_reg;
            i_day_reg   <= i_dprod[15:11] + 5'd1;
            i_wd_reg    <= h_wd_reg;
            i_bad_reg   <= h_bad_reg;
        end
    end

    assign out_valid      = valid_reg[NSTAGE-1];
    assign day_number_out = i_jdn_reg;
    assign year_out       = i_year_reg;
    assign month_out      = i_month_reg;
    assign day_out        = i_day_reg;
    assign weekday        = i_wd_reg;
    assign invalid        = i_bad_reg;

endmodule

// ===== design/gregorian_julian_day_converter.sv =====
// ----------------------------------------------------------------------------
// gregorian_julian_day_converter
// Converts dates, day numbers or Unix seconds to day number, date and weekday.
// ----------------------------------------------------------------------------
// Each beat passes through front stages A and B, then Richards stages C to I.
// Throughput: one beat per cycle while not stalled; each of the nine stages holds one item.
// A stalled output holds its beat; earlier stages keep filling any bubbles.
// Reset (rst_n low, asynchronous) clears all stage valid bits only.
module gregorian_julian_day_converter
    import gjd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [11:0] year_in,
    input  logic [3:0]  month_in,
    input  logic [4:0]  day_in,
    input  logic [21:0] day_number_in,
    input  logic [34:0] unix_seconds,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [21:0] day_number_out,
    output logic [11:0] year_out,
    output logic [3:0]  month_out,
    output logic [4:0]  day_out,
    output logic [2:0]  weekday,
    output logic        invalid
);

    logic      mid_valid;
    logic      mid_ready;
    jdn_item_t mid_item;

    gjd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .year_in       (year_in),
        .month_in      (month_in),
        .day_in        (day_in),
        .day_number_in (day_number_in),
        .unix_seconds  (unix_seconds),
        .out_valid     (mid_valid),
        .out_ready     (mid_ready),
        .out_item      (mid_item)
    );

    gjd_richards u_richards (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (mid_valid),
        .in_ready       (mid_ready),
        .in_item        (mid_item),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .day_number_out (day_number_out),
        .year_out       (year_out),
        .month_out      (month_out),
        .day_out        (day_out),
        .weekday        (weekday),
        .invalid        (invalid)
    );

endmodule

// ===== design/gjd_checker.sv =====
// ----------------------------------------------------------------------------
// gjd_checker
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
module gjd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [21:0] day_number_out,
    input logic [11:0] year_out,
    input logic [3:0]  month_out,
    input logic [4:0]  day_out,
    input logic [2:0]  weekday,
    input logic        invalid
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(day_number_out) && $stable(year_out) &&
                                    $stable(month_out) && $stable(day_out) &&
                                    $stable(weekday) && $stable(invalid))
        else $error("stalled output beat changed");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with an empty output");

    a_weekday: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> weekday != 3'd0)
        else $error("weekday out of range");

    a_valid_date: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !invalid |-> year_out >= 12'd1858 && year_out <= 12'd2558 &&
                                  month_out >= 4'd1 && month_out <= 4'd12 &&
                                  day_out != 5'd0)
        else $error("date flagged valid but out of range");

endmodule

bind gregorian_julian_day_converter gjd_checker u_gjd_checker (.*);
